// ----- sv/sasa_pkg.sv -----
// ============================================================================
// sasa_pkg: shared types, widths and tables
// Widths of the projection, corner and CORDIC datapaths, the register
// index codes and the arctangent table used by every CORDIC cell.
// ============================================================================
package sasa_pkg;

    // Input and configuration widths
    localparam int POS_W   = 32;            // Q16.16 position component
    localparam int VEC_W   = 21;            // Q1.19 vector component
    localparam int CFG_W   = 3 * VEC_W;     // packed vector register
    localparam int AP_W    = 31;            // full aperture, Q16.16
    localparam int SCALE_W = 32;            // emission scale, Q16.16
    localparam int IDX_W   = 3;             // configuration index

    // Projection datapath
    localparam int PRODP_W = VEC_W + POS_W;     // one component product
    localparam int PROJ_W  = PRODP_W + 1;       // sum of three products
    localparam int H_W     = AP_W + 18;         // half aperture in Q.35
    localparam int DIFF_W  = PROJ_W + 1;        // corner difference

    // Corner datapath
    localparam int NORM_W  = 30;                // normalized magnitude
    localparam int SQ_W    = 2 * NORM_W + 2;    // sum of three squares
    localparam int RT_W    = NORM_W + 1;        // square root
    localparam int TRIAL_W = 2 * RT_W + 2;      // square root trial term
    localparam int PRODX_W = NORM_W + RT_W;     // n * r
    localparam int SHIFT_W = 6;                 // normalizing shift count
    localparam int CORD_W  = NORM_W + 4;        // CORDIC x and y
    localparam int ANG_W   = NORM_W + 3;        // CORDIC angle, Q.30
    localparam int STEP_W  = 5;                 // cell step index

    // Pipeline depths
    localparam int ATAN_ITERATIONS = 20;
    localparam int SQRT_STEPS      = RT_W;
    localparam int CORNER_LAT      = 11 + SQRT_STEPS + ATAN_ITERATIONS;
    localparam int VLAT            = CORNER_LAT + 5;

    // Output stage
    localparam int SUM_W  = ANG_W + 2;          // four corner angles
    localparam int RS_W   = SUM_W - 6;          // sum rounded to Q.24
    localparam int MUL_W  = RS_W + SCALE_W;     // scaled sum
    localparam int RND_W  = MUL_W - 24;         // rounded to Q16.16
    localparam int OUT_W  = 32;

    typedef enum logic [IDX_W-1:0] {
        CFG_NORMAL    = 3'd0,
        CFG_PLANE_ONE = 3'd1,
        CFG_PLANE_TWO = 3'd2,
        CFG_APERTURE  = 3'd3,
        CFG_SCALE     = 3'd4
    } cfg_reg_t;

    // Values that ride along the square root chain
    typedef struct packed {
        logic                  neg;
        logic [NORM_W-1:0]     n;
        logic [2*NORM_W-1:0]   y;
    } sqrt_carry_t;

    // atan(2^-i) * 2^30, truncated
    function automatic logic [NORM_W-1:0] atan_const(input logic [STEP_W-1:0] i);
        logic [NORM_W-1:0] t;
        case (i)
            5'd0:    t = 30'd843314856;
            5'd1:    t = 30'd497837829;
            5'd2:    t = 30'd263043836;
            5'd3:    t = 30'd133525158;
            5'd4:    t = 30'd67021686;
            5'd5:    t = 30'd33543515;
            5'd6:    t = 30'd16775850;
            5'd7:    t = 30'd8388437;
            5'd8:    t = 30'd4194282;
            5'd9:    t = 30'd2097149;
            5'd10:   t = 30'd1048575;
            5'd11:   t = 30'd524287;
            5'd12:   t = 30'd262143;
            5'd13:   t = 30'd131071;
            5'd14:   t = 30'd65535;
            5'd15:   t = 30'd32767;
            5'd16:   t = 30'd16383;
            5'd17:   t = 30'd8191;
            5'd18:   t = 30'd4095;
            5'd19:   t = 30'd2047;
            5'd20:   t = 30'd1023;
            5'd21:   t = 30'd511;
            5'd22:   t = 30'd255;
            5'd23:   t = 30'd127;
            5'd24:   t = 30'd63;
            5'd25:   t = 30'd31;
            5'd26:   t = 30'd15;
            5'd27:   t = 30'd7;
            5'd28:   t = 30'd3;
            5'd29:   t = 30'd1;
            default: t = 30'd0;
        endcase
        return t;
    endfunction

    // Smallest right shift that brings m below 2^30
    function automatic logic [SHIFT_W-1:0] norm_shift(input logic [PRODX_W-1:0] m);
        logic [SHIFT_W-1:0] len;
        len = '0;
        for (int k = 0; k < PRODX_W; k++)
        begin
            if (m[k])
            begin
                len = SHIFT_W'(k + 1);
            end
        end
        return (len > SHIFT_W'(NORM_W)) ? (len - SHIFT_W'(NORM_W)) : '0;
    endfunction

endpackage

// ----- sv/square_aperture_solid_angle_top.sv -----
// ============================================================================
// square_aperture_solid_angle_top: solid-angle power of a square aperture
// Pipelined kernel: one particle position in, one power result out.
// ============================================================================
// Usage:
//   Write the detector normal, the two in-plane vectors, the aperture side
//   and the emission scale over the cfg channel (index 0..4, ready always
//   high, unknown indexes dropped) while no request is in flight.
//   Each request on the s_ channel carries pos_x/pos_y/pos_z. The m_ channel
//   returns power_out in m_tdata and the degenerate flag in m_tuser.
//   Throughput: one request per clock unless a stalled result freezes the
//   chain. The pipeline depth is set by the 31-cell square root chain and
//   the CORDIC cell chain in each of the four parallel corner lanes.
//   Reset clears all valid bits and returns the registers to their defaults
//   (emission scale 1.0, everything else zero).
//   When the receiver stalls, the result holds in the output register; the
//   pipeline keeps advancing and taking requests until a valid result
//   reaches the last stage, then the whole chain freezes together.
// ============================================================================
module square_aperture_solid_angle_top
(
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration write channel
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [sasa_pkg::IDX_W-1:0]      cfg_index,
    input  logic [sasa_pkg::CFG_W-1:0]      cfg_data,
    // input stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [3*sasa_pkg::POS_W-1:0]    s_tdata,   // pos_x, pos_y, pos_z
    // output stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [sasa_pkg::OUT_W-1:0]      m_tdata,   // power_out
    output logic                            m_tuser    // degenerate
);

    localparam int VW = sasa_pkg::VEC_W;
    localparam int PW = sasa_pkg::POS_W;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [sasa_pkg::CFG_W-1:0]         vec_reg [0:2];
    logic [sasa_pkg::AP_W-1:0]          aperture_reg;
    logic signed [sasa_pkg::SCALE_W-1:0] scale_reg;
    logic [sasa_pkg::H_W-1:0]           half_ap;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vec_reg[0]   <= '0;
            vec_reg[1]   <= '0;
            vec_reg[2]   <= '0;
            aperture_reg <= '0;
            scale_reg    <= sasa_pkg::SCALE_W'(65536);
        end
        else if (cfg_valid)
        begin
            case (sasa_pkg::cfg_reg_t'(cfg_index))
                sasa_pkg::CFG_NORMAL:    vec_reg[0]   <= cfg_data;
                sasa_pkg::CFG_PLANE_ONE: vec_reg[1]   <= cfg_data;
                sasa_pkg::CFG_PLANE_TWO: vec_reg[2]   <= cfg_data;
                sasa_pkg::CFG_APERTURE:  aperture_reg <= cfg_data[sasa_pkg::AP_W-1:0];
                sasa_pkg::CFG_SCALE:     scale_reg    <= $signed(cfg_data[sasa_pkg::SCALE_W-1:0]);
                default:                 ;
            endcase
        end
    end

    // half aperture in Q.35: (side / 2) << 19
    assign half_ap = {aperture_reg, 18'd0};

    // ------------------------------------------------------------------
    // Flow control: advance unless a valid result is stuck at the end
    // ------------------------------------------------------------------
    logic                      en;
    logic                      valid_reg [0:sasa_pkg::VLAT-1];
    logic                      deg_reg   [0:sasa_pkg::VLAT-2];
    logic                      out_valid_reg;
    logic                      out_load;

    assign en       = !valid_reg[sasa_pkg::VLAT-1] || !out_valid_reg || m_tready;
    assign s_tready = en;
    assign out_load = m_tready || !out_valid_reg;

    // ------------------------------------------------------------------
    // Projection: nine products, then three sums
    // ------------------------------------------------------------------
    logic signed [PW-1:0]                pos   [0:2];
    logic signed [sasa_pkg::PRODP_W-1:0] prod_reg [0:8];
    logic signed [sasa_pkg::PROJ_W-1:0]  proj_next [0:2];
    logic signed [sasa_pkg::PROJ_W-1:0]  proj_reg  [0:2];

    for (genvar c = 0; c < 3; c++)
    begin : g_pos
        assign pos[c] = $signed(s_tdata[c*PW +: PW]);
    end

    for (genvar v = 0; v < 3; v++)
    begin : g_proj
        for (genvar c = 0; c < 3; c++)
        begin : g_comp
            logic signed [VW-1:0] comp;
            assign comp = $signed(vec_reg[v][c*VW +: VW]);

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    prod_reg[3*v+c] <= comp * pos[c];
                end
            end
        end

        assign proj_next[v] = sasa_pkg::PROJ_W'(prod_reg[3*v])
                            + sasa_pkg::PROJ_W'(prod_reg[3*v+1])
                            + sasa_pkg::PROJ_W'(prod_reg[3*v+2]);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                proj_reg[v] <= proj_next[v];
            end
        end
    end

    // ------------------------------------------------------------------
    // Four corner lanes: (+h,+h), (-h,-h), (-h,+h), (+h,-h)
    // ------------------------------------------------------------------
    logic signed [sasa_pkg::ANG_W-1:0] ang_pp;
    logic signed [sasa_pkg::ANG_W-1:0] ang_mm;
    logic signed [sasa_pkg::ANG_W-1:0] ang_mp;
    logic signed [sasa_pkg::ANG_W-1:0] ang_pm;

    sasa_corner u_corner_pp
    (
        .clk(clk), .en(en), .l1_neg(1'b0), .l2_neg(1'b0),
        .cn(proj_reg[0]), .c1(proj_reg[1]), .c2(proj_reg[2]),
        .half_ap(half_ap), .angle(ang_pp)
    );

    sasa_corner u_corner_mm
    (
        .clk(clk), .en(en), .l1_neg(1'b1), .l2_neg(1'b1),
        .cn(proj_reg[0]), .c1(proj_reg[1]), .c2(proj_reg[2]),
        .half_ap(half_ap), .angle(ang_mm)
    );

    sasa_corner u_corner_mp
    (
        .clk(clk), .en(en), .l1_neg(1'b1), .l2_neg(1'b0),
        .cn(proj_reg[0]), .c1(proj_reg[1]), .c2(proj_reg[2]),
        .half_ap(half_ap), .angle(ang_mp)
    );

    sasa_corner u_corner_pm
    (
        .clk(clk), .en(en), .l1_neg(1'b0), .l2_neg(1'b1),
        .cn(proj_reg[0]), .c1(proj_reg[1]), .c2(proj_reg[2]),
        .half_ap(half_ap), .angle(ang_pm)
    );

    // ------------------------------------------------------------------
    // Combine, round to Q.24, scale, round to Q16.16
    // ------------------------------------------------------------------
    logic signed [sasa_pkg::SUM_W-1:0] sum_reg;
    logic signed [sasa_pkg::SUM_W-1:0] sum_rnd;
    logic signed [sasa_pkg::RS_W-1:0]  rs_reg;
    logic signed [sasa_pkg::MUL_W-1:0] mul_reg;
    logic signed [sasa_pkg::MUL_W-1:0] mul_rnd;
    logic signed [sasa_pkg::RND_W-1:0] rnd;
    logic signed [sasa_pkg::OUT_W-1:0] sat;
    logic [sasa_pkg::OUT_W-1:0]        data_reg;
    logic                              user_reg;

    assign sum_rnd = sum_reg + sasa_pkg::SUM_W'(32);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum_reg <= sasa_pkg::SUM_W'(ang_pp) + sasa_pkg::SUM_W'(ang_mm)
                     - sasa_pkg::SUM_W'(ang_mp) - sasa_pkg::SUM_W'(ang_pm);
            rs_reg  <= sasa_pkg::RS_W'(sum_rnd >>> 6);
            mul_reg <= sasa_pkg::MUL_W'(rs_reg) * sasa_pkg::MUL_W'(scale_reg);
        end
    end

    // saturate the Q16.16 result to the 32-bit range
    always_comb
    begin
        mul_rnd = mul_reg + sasa_pkg::MUL_W'(1 << 23);
        rnd     = sasa_pkg::RND_W'(mul_rnd >>> 24);
        if (rnd[sasa_pkg::RND_W-1:sasa_pkg::OUT_W-1] == '0
            || rnd[sasa_pkg::RND_W-1:sasa_pkg::OUT_W-1] == '1)
        begin
            sat = rnd[sasa_pkg::OUT_W-1:0];
        end
        else if (rnd[sasa_pkg::RND_W-1])
        begin
            sat = {1'b1, {(sasa_pkg::OUT_W-1){1'b0}}};
        end
        else
        begin
            sat = {1'b0, {(sasa_pkg::OUT_W-1){1'b1}}};
        end
    end

    // ------------------------------------------------------------------
    // Valid and degenerate lines alongside the datapath
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < sasa_pkg::VLAT; k++)
            begin
                valid_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            valid_reg[0] <= s_tvalid;
            for (int k = 1; k < sasa_pkg::VLAT; k++)
            begin
                valid_reg[k] <= valid_reg[k-1];
            end
        end
    end

    // degenerate when the normal projection is exactly zero
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            deg_reg[0] <= (proj_next[0] == '0);
            for (int k = 1; k < sasa_pkg::VLAT - 1; k++)
            begin
                deg_reg[k] <= deg_reg[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register: load when empty or being drained
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= valid_reg[sasa_pkg::VLAT-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            data_reg <= deg_reg[sasa_pkg::VLAT-2] ? '0 : sat;
            user_reg <= deg_reg[sasa_pkg::VLAT-2];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = user_reg;

endmodule

// ----- sv/sasa_sqrt_cell.sv -----
// ============================================================================
// sasa_sqrt_cell: one digit of the square root chain
// Decides one root bit against the running remainder and hands the
// remainder, partial root and side values to the next cell.
// ============================================================================
module sasa_sqrt_cell
(
    input  logic                             clk,
    input  logic                             en,
    input  logic [sasa_pkg::STEP_W-1:0]      bit_idx,
    input  logic [sasa_pkg::SQ_W-1:0]        rem_in,
    input  logic [sasa_pkg::RT_W-1:0]        root_in,
    input  sasa_pkg::sqrt_carry_t            carry_in,
    output logic [sasa_pkg::SQ_W-1:0]        rem_out,
    output logic [sasa_pkg::RT_W-1:0]        root_out,
    output sasa_pkg::sqrt_carry_t            carry_out
);

    logic [sasa_pkg::TRIAL_W-1:0] trial;
    logic                         take;
    logic [sasa_pkg::SQ_W-1:0]    rem_next;
    logic [sasa_pkg::RT_W-1:0]    root_next;
    logic [sasa_pkg::SQ_W-1:0]    rem_reg;
    logic [sasa_pkg::RT_W-1:0]    root_reg;
    sasa_pkg::sqrt_carry_t        carry_reg;

    // (root + 2^k)^2 - root^2 = root * 2^(k+1) + 2^(2k)
    always_comb
    begin
        trial = (sasa_pkg::TRIAL_W'(root_in) << (bit_idx + 5'd1))
              + (sasa_pkg::TRIAL_W'(1) << {bit_idx, 1'b0});
        take  = sasa_pkg::TRIAL_W'(rem_in) >= trial;
        rem_next  = take ? sasa_pkg::SQ_W'(sasa_pkg::TRIAL_W'(rem_in) - trial) : rem_in;
        root_next = take ? (root_in | (sasa_pkg::RT_W'(1) << bit_idx)) : root_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg   <= rem_next;
            root_reg  <= root_next;
            carry_reg <= carry_in;
        end
    end

    assign rem_out   = rem_reg;
    assign root_out  = root_reg;
    assign carry_out = carry_reg;

endmodule

// ----- sv/sasa_cordic_cell.sv -----
// ============================================================================
// sasa_cordic_cell: one CORDIC vectoring step
// Rotates (x, y) toward the x axis by atan(2^-i) and accumulates the angle.
// ============================================================================
module sasa_cordic_cell
(
    input  logic                                clk,
    input  logic                                en,
    input  logic [sasa_pkg::STEP_W-1:0]         step,
    input  logic signed [sasa_pkg::CORD_W-1:0]  x_in,
    input  logic signed [sasa_pkg::CORD_W-1:0]  y_in,
    input  logic signed [sasa_pkg::ANG_W-1:0]   z_in,
    input  logic                                neg_in,
    output logic signed [sasa_pkg::CORD_W-1:0]  x_out,
    output logic signed [sasa_pkg::CORD_W-1:0]  y_out,
    output logic signed [sasa_pkg::ANG_W-1:0]   z_out,
    output logic                                neg_out
);

    logic signed [sasa_pkg::CORD_W-1:0] dx;
    logic signed [sasa_pkg::CORD_W-1:0] dy;
    logic signed [sasa_pkg::ANG_W-1:0]  tab;
    logic signed [sasa_pkg::CORD_W-1:0] x_next;
    logic signed [sasa_pkg::CORD_W-1:0] y_next;
    logic signed [sasa_pkg::ANG_W-1:0]  z_next;
    logic signed [sasa_pkg::CORD_W-1:0] x_reg;
    logic signed [sasa_pkg::CORD_W-1:0] y_reg;
    logic signed [sasa_pkg::ANG_W-1:0]  z_reg;
    logic                               neg_reg;

    always_comb
    begin
        dx  = y_in >>> step;
        dy  = x_in >>> step;
        tab = $signed({{(sasa_pkg::ANG_W - sasa_pkg::NORM_W){1'b0}},
                       sasa_pkg::atan_const(step)});
        if (!y_in[sasa_pkg::CORD_W-1])
        begin
            x_next = x_in + dx;
            y_next = y_in - dy;
            z_next = z_in + tab;
        end
        else
        begin
            x_next = x_in - dx;
            y_next = y_in + dy;
            z_next = z_in - tab;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg   <= x_next;
            y_reg   <= y_next;
            z_reg   <= z_next;
            neg_reg <= neg_in;
        end
    end

    assign x_out   = x_reg;
    assign y_out   = y_reg;
    assign z_out   = z_reg;
    assign neg_out = neg_reg;

endmodule

// ----- sv/sasa_corner.sv -----
// ============================================================================
// sasa_corner: arctangent term of one aperture corner
// Offsets the projections by the corner, normalizes, takes the root of the
// squared distance through a chain of root cells, normalizes again and
// runs a chain of CORDIC cells.
// ============================================================================
module sasa_corner
(
    input  logic                                clk,
    input  logic                                en,
    input  logic                                l1_neg,
    input  logic                                l2_neg,
    input  logic signed [sasa_pkg::PROJ_W-1:0]  cn,
    input  logic signed [sasa_pkg::PROJ_W-1:0]  c1,
    input  logic signed [sasa_pkg::PROJ_W-1:0]  c2,
    input  logic [sasa_pkg::H_W-1:0]            half_ap,
    output logic signed [sasa_pkg::ANG_W-1:0]   angle
);

    localparam int DW = sasa_pkg::DIFF_W;
    localparam int NW = sasa_pkg::NORM_W;
    localparam int XW = sasa_pkg::PRODX_W;

    // Stage 1: corner offsets and magnitudes
    logic signed [DW-1:0] hx;
    logic signed [DW-1:0] d1;
    logic signed [DW-1:0] d2;
    logic signed [DW-1:0] dn;
    logic [DW-1:0]        a1_reg;
    logic [DW-1:0]        b1_reg;
    logic [DW-1:0]        n1_reg;
    logic                 neg1_reg;

    always_comb
    begin
        hx = $signed({{(DW - sasa_pkg::H_W){1'b0}}, half_ap});
        d1 = l1_neg ? (DW'(c1) + hx) : (DW'(c1) - hx);
        d2 = l2_neg ? (DW'(c2) + hx) : (DW'(c2) - hx);
        dn = DW'(cn);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a1_reg   <= d1[DW-1] ? DW'(-d1) : DW'(d1);
            b1_reg   <= d2[DW-1] ? DW'(-d2) : DW'(d2);
            n1_reg   <= dn[DW-1] ? DW'(-dn) : DW'(dn);
            neg1_reg <= d1[DW-1] ^ d2[DW-1] ^ dn[DW-1];
        end
    end

    // Stage 2: largest magnitude
    logic [DW-1:0] a2_reg;
    logic [DW-1:0] b2_reg;
    logic [DW-1:0] n2_reg;
    logic [DW-1:0] m2_reg;
    logic          neg2_reg;
    logic [DW-1:0] m_ab;

    always_comb
    begin
        m_ab = (b1_reg > a1_reg) ? b1_reg : a1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a2_reg   <= a1_reg;
            b2_reg   <= b1_reg;
            n2_reg   <= n1_reg;
            m2_reg   <= (n1_reg > m_ab) ? n1_reg : m_ab;
            neg2_reg <= neg1_reg;
        end
    end

    // Stage 3: shift count
    logic [DW-1:0]                a3_reg;
    logic [DW-1:0]                b3_reg;
    logic [DW-1:0]                n3_reg;
    logic [sasa_pkg::SHIFT_W-1:0] s3_reg;
    logic                         neg3_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a3_reg   <= a2_reg;
            b3_reg   <= b2_reg;
            n3_reg   <= n2_reg;
            s3_reg   <= sasa_pkg::norm_shift(XW'(m2_reg));
            neg3_reg <= neg2_reg;
        end
    end

    // Stage 4: common normalizing shift
    logic [NW-1:0] a4_reg;
    logic [NW-1:0] b4_reg;
    logic [NW-1:0] n4_reg;
    logic          neg4_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a4_reg   <= NW'(a3_reg >> s3_reg);
            b4_reg   <= NW'(b3_reg >> s3_reg);
            n4_reg   <= NW'(n3_reg >> s3_reg);
            neg4_reg <= neg3_reg;
        end
    end

    // Stage 5: squares and numerator
    logic [2*NW-1:0] nn5_reg;
    logic [2*NW-1:0] aa5_reg;
    logic [2*NW-1:0] bb5_reg;
    logic [2*NW-1:0] y5_reg;
    logic [NW-1:0]   n5_reg;
    logic            neg5_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nn5_reg  <= n4_reg * n4_reg;
            aa5_reg  <= a4_reg * a4_reg;
            bb5_reg  <= b4_reg * b4_reg;
            y5_reg   <= a4_reg * b4_reg;
            n5_reg   <= n4_reg;
            neg5_reg <= neg4_reg;
        end
    end

    // Stage 6: squared distance
    logic [sasa_pkg::SQ_W-1:0] v6_reg;
    sasa_pkg::sqrt_carry_t     carry6_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v6_reg <= sasa_pkg::SQ_W'(nn5_reg) + sasa_pkg::SQ_W'(aa5_reg)
                    + sasa_pkg::SQ_W'(bb5_reg);
            carry6_reg.neg <= neg5_reg;
            carry6_reg.n   <= n5_reg;
            carry6_reg.y   <= y5_reg;
        end
    end

    // Square root chain, most significant root bit first
    logic [sasa_pkg::SQ_W-1:0] rem_w   [0:sasa_pkg::SQRT_STEPS];
    logic [sasa_pkg::RT_W-1:0] root_w  [0:sasa_pkg::SQRT_STEPS];
    sasa_pkg::sqrt_carry_t     carry_w [0:sasa_pkg::SQRT_STEPS];

    assign rem_w[0]   = v6_reg;
    assign root_w[0]  = '0;
    assign carry_w[0] = carry6_reg;

    for (genvar j = 0; j < sasa_pkg::SQRT_STEPS; j++)
    begin : g_sqrt
        sasa_sqrt_cell u_cell
        (
            .clk       (clk),
            .en        (en),
            .bit_idx   (sasa_pkg::STEP_W'(sasa_pkg::SQRT_STEPS - 1 - j)),
            .rem_in    (rem_w[j]),
            .root_in   (root_w[j]),
            .carry_in  (carry_w[j]),
            .rem_out   (rem_w[j+1]),
            .root_out  (root_w[j+1]),
            .carry_out (carry_w[j+1])
        );
    end

    // Stage M1: denominator n * r
    sasa_pkg::sqrt_carry_t cfin;
    logic [XW-1:0]         xm1_reg;
    logic [XW-1:0]         ym1_reg;
    logic                  negm1_reg;

    assign cfin = carry_w[sasa_pkg::SQRT_STEPS];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xm1_reg   <= cfin.n * root_w[sasa_pkg::SQRT_STEPS];
            ym1_reg   <= XW'(cfin.y);
            negm1_reg <= cfin.neg;
        end
    end

    // Stage M2: larger of numerator and denominator
    logic [XW-1:0] xm2_reg;
    logic [XW-1:0] ym2_reg;
    logic [XW-1:0] mm2_reg;
    logic          negm2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xm2_reg   <= xm1_reg;
            ym2_reg   <= ym1_reg;
            mm2_reg   <= (xm1_reg > ym1_reg) ? xm1_reg : ym1_reg;
            negm2_reg <= negm1_reg;
        end
    end

    // Stage M3: shift count
    logic [XW-1:0]                xm3_reg;
    logic [XW-1:0]                ym3_reg;
    logic [sasa_pkg::SHIFT_W-1:0] sm3_reg;
    logic                         negm3_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xm3_reg   <= xm2_reg;
            ym3_reg   <= ym2_reg;
            sm3_reg   <= sasa_pkg::norm_shift(mm2_reg);
            negm3_reg <= negm2_reg;
        end
    end

    // Stage M4: normalize into the CORDIC range
    logic signed [sasa_pkg::CORD_W-1:0] xm4_reg;
    logic signed [sasa_pkg::CORD_W-1:0] ym4_reg;
    logic                               negm4_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xm4_reg   <= $signed({{(sasa_pkg::CORD_W - NW){1'b0}}, NW'(xm3_reg >> sm3_reg)});
            ym4_reg   <= $signed({{(sasa_pkg::CORD_W - NW){1'b0}}, NW'(ym3_reg >> sm3_reg)});
            negm4_reg <= negm3_reg;
        end
    end

    // CORDIC chain
    logic signed [sasa_pkg::CORD_W-1:0] cx_w   [0:sasa_pkg::ATAN_ITERATIONS];
    logic signed [sasa_pkg::CORD_W-1:0] cy_w   [0:sasa_pkg::ATAN_ITERATIONS];
    logic signed [sasa_pkg::ANG_W-1:0]  cz_w   [0:sasa_pkg::ATAN_ITERATIONS];
    logic                               cneg_w [0:sasa_pkg::ATAN_ITERATIONS];

    assign cx_w[0]   = xm4_reg;
    assign cy_w[0]   = ym4_reg;
    assign cz_w[0]   = '0;
    assign cneg_w[0] = negm4_reg;

    for (genvar i = 0; i < sasa_pkg::ATAN_ITERATIONS; i++)
    begin : g_cordic
        sasa_cordic_cell u_cell
        (
            .clk     (clk),
            .en      (en),
            .step    (sasa_pkg::STEP_W'(i)),
            .x_in    (cx_w[i]),
            .y_in    (cy_w[i]),
            .z_in    (cz_w[i]),
            .neg_in  (cneg_w[i]),
            .x_out   (cx_w[i+1]),
            .y_out   (cy_w[i+1]),
            .z_out   (cz_w[i+1]),
            .neg_out (cneg_w[i+1])
        );
    end

    // Final stage: apply the quadrant sign
    logic signed [sasa_pkg::ANG_W-1:0] angle_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            angle_reg <= cneg_w[sasa_pkg::ATAN_ITERATIONS]
                       ? -cz_w[sasa_pkg::ATAN_ITERATIONS]
                       : cz_w[sasa_pkg::ATAN_ITERATIONS];
        end
    end

    assign angle = angle_reg;

endmodule

// ----- test/square_aperture_solid_angle_checker.sv -----
`timescale 1ns / 100ps
// ============================================================================
// square_aperture_solid_angle_checker: power prediction and result checking
// Watches the configuration, request and result channels, keeps its own copy
// of the detector registers, predicts the power of each accepted position and
// compares every accepted result with the oldest prediction.
// ============================================================================
module square_aperture_solid_angle_checker
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [sasa_pkg::IDX_W-1:0]      cfg_index,
    input  logic [sasa_pkg::CFG_W-1:0]      cfg_data,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [3*sasa_pkg::POS_W-1:0]    s_tdata,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [sasa_pkg::OUT_W-1:0]      m_tdata,
    input  logic                            m_tuser,
    output int                              fail_count,
    output int                              powers_pending
);

    typedef struct {
        logic [31:0] power;
        logic        degen;
    } power_result_t;

    localparam longint unsigned NORM_LIMIT = 64'd1 << 30;

    localparam longint ARCTAN_Q30 [32] = '{
        843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
        16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143, 131071,
        65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127, 63, 31,
        15, 7, 3, 1, 0, 0
    };

    logic [sasa_pkg::CFG_W-1:0]   det_normal;
    logic [sasa_pkg::CFG_W-1:0]   det_axis_one;
    logic [sasa_pkg::CFG_W-1:0]   det_axis_two;
    logic [sasa_pkg::AP_W-1:0]    det_aperture;
    logic [sasa_pkg::SCALE_W-1:0] det_scale;

    power_result_t expected_powers [$];

    assign powers_pending = expected_powers.size();

    function automatic longint vec_comp(input logic [sasa_pkg::CFG_W-1:0] v, input int k);
        logic signed [sasa_pkg::VEC_W-1:0] c;
        c = v[k*sasa_pkg::VEC_W +: sasa_pkg::VEC_W];
        return longint'(c);
    endfunction

    function automatic longint dot(input logic [sasa_pkg::CFG_W-1:0] v, input longint px,
                                   input longint py, input longint pz);
        return vec_comp(v, 0) * px + vec_comp(v, 1) * py + vec_comp(v, 2) * pz;
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned r;
        longint unsigned bit_w;
        r = 0;
        bit_w = 64'd1 << 62;
        while (bit_w > v)
            bit_w = bit_w >> 2;
        while (bit_w != 0)
        begin
            if (v >= r + bit_w)
            begin
                v = v - (r + bit_w);
                r = (r >> 1) + bit_w;
            end
            else
            begin
                r = r >> 1;
            end
            bit_w = bit_w >> 2;
        end
        return r;
    endfunction

    // Vectoring CORDIC: angle of (x, y) in Q.30 radians
    function automatic longint arctan_q30(input longint x, input longint y);
        longint z;
        longint dx;
        longint dy;
        z = 0;
        for (int i = 0; i < sasa_pkg::ATAN_ITERATIONS && i < 32; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0)
            begin
                x = x + dx;
                y = y - dy;
                z = z + ARCTAN_Q30[i];
            end
            else
            begin
                x = x - dx;
                y = y + dy;
                z = z - ARCTAN_Q30[i];
            end
        end
        return z;
    endfunction

    function automatic longint corner_angle(input longint l1, input longint l2,
                                            input longint cn, input longint c1,
                                            input longint c2);
        longint d1;
        longint d2;
        logic neg;
        longint unsigned a, b, n, m, x, y, r;
        int s;
        longint z;
        d1 = c1 - l1;
        d2 = c2 - l2;
        neg = (d1 < 0) ^ (d2 < 0) ^ (cn < 0);
        a = (d1 < 0) ? -d1 : d1;
        b = (d2 < 0) ? -d2 : d2;
        n = (cn < 0) ? -cn : cn;
        m = a;
        if (b > m) m = b;
        if (n > m) m = n;
        s = 0;
        while ((m >> s) >= NORM_LIMIT)
            s++;
        a = a >> s;
        b = b >> s;
        n = n >> s;
        r = int_sqrt(n * n + a * a + b * b);
        x = n * r;
        y = a * b;
        m = (x > y) ? x : y;
        s = 0;
        while ((m >> s) >= NORM_LIMIT)
            s++;
        x = x >> s;
        y = y >> s;
        z = arctan_q30(longint'(x), longint'(y));
        return neg ? -z : z;
    endfunction

    function automatic power_result_t predict_power(input logic [3*sasa_pkg::POS_W-1:0] pos);
        power_result_t res;
        longint px, py, pz, cn, c1, c2, h, sum, p;
        px = longint'($signed(pos[31:0]));
        py = longint'($signed(pos[63:32]));
        pz = longint'($signed(pos[95:64]));
        cn = dot(det_normal, px, py, pz);
        c1 = dot(det_axis_one, px, py, pz);
        c2 = dot(det_axis_two, px, py, pz);
        h = longint'(det_aperture) << 18;
        if (cn == 0)
        begin
            res.power = '0;
            res.degen = 1'b1;
            return res;
        end
        sum = corner_angle(h, h, cn, c1, c2) + corner_angle(-h, -h, cn, c1, c2)
            - corner_angle(-h, h, cn, c1, c2) - corner_angle(h, -h, cn, c1, c2);
        p = (((sum + 32) >>> 6) * longint'($signed(det_scale)) + (64'sd1 <<< 23)) >>> 24;
        if (p > 64'sd2147483647) p = 64'sd2147483647;
        if (p < -64'sd2147483648) p = -64'sd2147483648;
        res.power = p[31:0];
        res.degen = 1'b0;
        return res;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            det_normal   <= '0;
            det_axis_one <= '0;
            det_axis_two <= '0;
            det_aperture <= '0;
            det_scale    <= 32'd65536;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                sasa_pkg::CFG_NORMAL:    det_normal   <= cfg_data;
                sasa_pkg::CFG_PLANE_ONE: det_axis_one <= cfg_data;
                sasa_pkg::CFG_PLANE_TWO: det_axis_two <= cfg_data;
                sasa_pkg::CFG_APERTURE:  det_aperture <= cfg_data[sasa_pkg::AP_W-1:0];
                sasa_pkg::CFG_SCALE:     det_scale    <= cfg_data[sasa_pkg::SCALE_W-1:0];
                default:                 ;
            endcase
        end
    end

    initial fail_count = 0;

    always @(posedge clk)
    begin
        power_result_t want;
        if (rst_n && s_tvalid && s_tready)
            expected_powers.push_back(predict_power(s_tdata));
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_powers.size() == 0)
            begin
                $error("unexpected result: power_out %h degenerate %b", m_tdata, m_tuser);
                fail_count++;
            end
            else
            begin
                want = expected_powers.pop_front();
                if (m_tdata !== want.power)
                begin
                    $error("power_out: expected %h actual %h", want.power, m_tdata);
                    fail_count++;
                end
                if (m_tuser !== want.degen)
                begin
                    $error("degenerate: expected %b actual %b", want.degen, m_tuser);
                    fail_count++;
                end
            end
        end
    end

endmodule

// ----- test/square_aperture_solid_angle_top_tb.sv -----
`timescale 1ns / 100ps
// ============================================================================
// square_aperture_solid_angle_top_tb: stimulus and verdict
// Drives detector setups and particle positions through the kernel under
// several handshake pressure phases; a checker beside the block predicts
// each power result and counts mismatches.
// ============================================================================
module square_aperture_solid_angle_top_tb;

    localparam int STALL_LIMIT = 5000;   // cycles without any handshake
    localparam int DRAIN_WAIT  = 100;    // extra wait after the last expected result

    logic                             clk;
    logic                             rst_n;
    logic                             cfg_valid;
    logic                             cfg_ready;
    logic [sasa_pkg::IDX_W-1:0]       cfg_index;
    logic [sasa_pkg::CFG_W-1:0]       cfg_data;
    logic                             s_tvalid;
    logic                             s_tready;
    logic [3*sasa_pkg::POS_W-1:0]     s_tdata;    // pos_x, pos_y, pos_z
    logic                             m_tvalid;
    logic                             m_tready;
    logic [sasa_pkg::OUT_W-1:0]       m_tdata;    // power_out
    logic                             m_tuser;    // degenerate

    int fail_count;
    int powers_pending;
    int send_idle_pct;
    int recv_stall_pct;
    int quiet_cycles;

    square_aperture_solid_angle_top dut
    (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    square_aperture_solid_angle_checker power_checker
    (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .fail_count(fail_count), .powers_pending(powers_pending)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Receiver: stall at random with the phase's rate
    initial m_tready = 1'b0;
    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= recv_stall_pct);

    // Watchdog: any accepted request, result or configuration write restarts the count
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)
            || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("FAIL square_aperture_solid_angle_top");
            $finish;
        end
    end

    // Q1.19 unit along one axis, with sign; most negative code for extremes
    function automatic logic [sasa_pkg::CFG_W-1:0] axis_vec(input int axis, input int sgn);
        logic [sasa_pkg::CFG_W-1:0] v;
        logic [sasa_pkg::VEC_W-1:0] c;
        v = '0;
        c = (sgn > 0) ? sasa_pkg::VEC_W'(524288) :
            (sgn < 0) ? sasa_pkg::VEC_W'(-524288) : sasa_pkg::VEC_W'(1 << 20);
        v[axis*sasa_pkg::VEC_W +: sasa_pkg::VEC_W] = c;
        return v;
    endfunction

    task automatic write_reg(input logic [sasa_pkg::IDX_W-1:0] idx,
                             input logic [sasa_pkg::CFG_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Hold valid across back-to-back requests; drop it only for a gap
    task automatic send_pos(input logic [31:0] px, input logic [31:0] py,
                            input logic [31:0] pz);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {pz, py, px};
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (powers_pending != 0)
            @(posedge clk);
        repeat (5) @(posedge clk);
    endtask

    function automatic logic [31:0] random_coord();
        int pick;
        pick = $urandom_range(99);
        if (pick < 55)
            return 32'($signed($urandom_range(8 << 16)) - (4 << 16));
        else if (pick < 90)
            return $urandom();
        else
            return 32'($signed($urandom_range(64)) - 32);
    endfunction

    initial
    begin
        logic [31:0] px, py, pz;
        int pick;
        rst_n          = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        quiet_cycles   = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset setup: every normal projection is zero
        send_pos(32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
        send_pos(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        drain_results();

        // Detector facing +z, unit aperture, unit emission
        write_reg(sasa_pkg::CFG_NORMAL, axis_vec(2, 1));
        write_reg(sasa_pkg::CFG_PLANE_ONE, axis_vec(0, 1));
        write_reg(sasa_pkg::CFG_PLANE_TWO, axis_vec(1, 1));
        write_reg(sasa_pkg::CFG_APERTURE, 63'd65536);
        write_reg(sasa_pkg::CFG_SCALE, 63'd65536);
        write_reg(sasa_pkg::IDX_W'(5), {sasa_pkg::CFG_W{1'b1}});     // unknown index: dropped
        write_reg(sasa_pkg::IDX_W'(7), '0);
        send_pos(32'h0, 32'h0, 32'h0001_0000);               // on axis
        send_pos(32'h0, 32'h0, 32'hFFFF_0000);               // behind detector
        send_pos(32'h0000_8000, 32'h0, 32'h0001_0000);       // over an edge: zero numerator
        send_pos(32'h0000_8000, 32'h0000_8000, 32'h0000_0100);
        send_pos(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0001); // tiny normal after scaling
        send_pos(32'h8000_0000, 32'h8000_0000, 32'h0000_0001);
        send_pos(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        send_pos(32'h1234_5678, 32'h0000_0000, 32'h0);       // in the detector plane
        send_pos(32'h0, 32'h0, 32'h8000_0000);
        send_pos(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        drain_results();

        // Extreme registers
        write_reg(sasa_pkg::CFG_NORMAL, {sasa_pkg::CFG_W{1'b1}} ^ 63'h0);
        write_reg(sasa_pkg::CFG_PLANE_ONE,
                  {axis_vec(2, 0) | axis_vec(1, 0) | axis_vec(0, 0)});
        write_reg(sasa_pkg::CFG_PLANE_TWO, 63'h7FFF_FFFF_FFFF_FFFF);
        write_reg(sasa_pkg::CFG_APERTURE, 63'h7FFF_FFFF);
        write_reg(sasa_pkg::CFG_SCALE, 63'h7FFF_FFFF);
        send_pos(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_pos(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_pos(32'h0001_0000, 32'h0, 32'h0);
        drain_results();
        write_reg(sasa_pkg::CFG_SCALE, 63'h8000_0000);
        write_reg(sasa_pkg::CFG_APERTURE, 63'd1);
        send_pos(32'h7FFF_FFFF, 32'h0, 32'h8000_0000);
        send_pos(32'h0, 32'h8000_0000, 32'h0001_0000);
        send_pos(32'h0000_0001, 32'h0, 32'h0);
        drain_results();

        // Random part: four pressure phases, several setups each
        for (int phase = 0; phase < 4; phase++)
        begin
            for (int setup = 0; setup < 4; setup++)
            begin
                send_idle_pct  = (phase == 1 || phase == 3) ? ((phase == 1) ? 78 : 30) : 0;
                recv_stall_pct = (phase == 2 || phase == 3) ? ((phase == 2) ? 78 : 30) : 0;
                if ($urandom_range(1) == 0)
                begin
                    // Orthonormal-like frame from signed axes
                    pick = $urandom_range(2);
                    write_reg(sasa_pkg::CFG_NORMAL,
                              axis_vec(pick, $urandom_range(1) ? 1 : -1));
                    write_reg(sasa_pkg::CFG_PLANE_ONE,
                              axis_vec((pick + 1) % 3, $urandom_range(1) ? 1 : -1));
                    write_reg(sasa_pkg::CFG_PLANE_TWO,
                              axis_vec((pick + 2) % 3, $urandom_range(1) ? 1 : -1));
                end
                else
                begin
                    write_reg(sasa_pkg::CFG_NORMAL, 63'({$urandom(), $urandom()}));
                    write_reg(sasa_pkg::CFG_PLANE_ONE, 63'({$urandom(), $urandom()}));
                    write_reg(sasa_pkg::CFG_PLANE_TWO, 63'({$urandom(), $urandom()}));
                end
                pick = $urandom_range(9);
                write_reg(sasa_pkg::CFG_APERTURE, (pick == 0) ? 63'h7FFF_FFFF :
                                        (pick < 3) ? 63'($urandom() >> 1)
                                                   : 63'($urandom_range(4 << 16)));
                pick = $urandom_range(9);
                write_reg(sasa_pkg::CFG_SCALE, (pick == 0) ? 63'h8000_0000 :
                                     (pick == 1) ? 63'h7FFF_FFFF :
                                     (pick < 4) ? 63'($urandom())
                                                : 63'($urandom_range(8 << 16)));
                for (int item = 0; item < 75; item++)
                begin
                    px = random_coord();
                    py = random_coord();
                    pz = random_coord();
                    if ($urandom_range(19) == 0)
                    begin
                        px = '0;
                        py = '0;
                        pz = '0;
                    end
                    send_pos(px, py, pz);
                end
                drain_results();
            end
        end

        // No more requests: wait out the pipeline
        s_tvalid <= 1'b0;
        recv_stall_pct = 0;
        while (powers_pending != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (fail_count == 0)
            $display("PASS square_aperture_solid_angle_top");
        else
            $display("FAIL square_aperture_solid_angle_top");
        $finish;
    end

endmodule
